// File: rtl/tlc_pkg.sv
// tlc_pkg: shared types, field widths and codes for the tile LRU cache.
// No dependencies; used by every module of the block.
`default_nettype none

package tlc_pkg;

  localparam int CAPACITY = 64;
  localparam int SCAN_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int LEVEL_W  = 5;
  localparam int COORD_W  = 16;
  localparam int HANDLE_W = 16;
  localparam int KEY_W    = LEVEL_W + 2 * COORD_W;
  localparam int OCC_W    = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_TOUCH  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [2:0] ST_IGNORED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_UPDATED  = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [HANDLE_W-1:0] handle_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [LEVEL_W-1:0] tile_level;
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    handle_t            item_handle;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             released_valid;
    logic             released_by_eviction;
    handle_t          released_handle;
    logic [OCC_W-1:0] occupancy;
  } out_word_t;

  // One cache entry as it moves along the chain
  typedef struct packed {
    logic    valid;
    key_t    key;
    handle_t handle;
  } entry_t;

  // Hit flag and hit handle rippling back towards the head
  typedef struct packed {
    logic    hit;
    handle_t handle;
  } scan_t;

  typedef struct packed {
    logic scan_en;
    logic shift_all;
    logic shift_hit;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/tlc_cell.sv
// tlc_cell: one entry slot of the recency chain, with its own key compare.
// Depends on tlc_pkg.
`default_nettype none

module tlc_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  tlc_pkg::key_t       req_key,
  input  tlc_pkg::cell_ctrl_t ctrl,
  input  tlc_pkg::entry_t     entry_in,   // from the more recent neighbour
  output tlc_pkg::entry_t     entry_out,  // this slot
  input  tlc_pkg::scan_t      scan_in,    // from the less recent neighbour
  output tlc_pkg::scan_t      scan_out
);
  import tlc_pkg::*;

  entry_t ent;
  scan_t  scan;
  logic   match;
  logic   shift;

  assign match = ent.valid && (ent.key == req_key);
  // cells from the head down to the hit slot move one place on a promote
  assign shift = ctrl.shift_all || (ctrl.shift_hit && scan.hit);

  // only the valid bit is reset; key and handle are read while valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (shift) begin
      ent.valid <= entry_in.valid;
    end
    if (shift) begin
      ent.key    <= entry_in.key;
      ent.handle <= entry_in.handle;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan_en) begin
      scan.hit    <= match || scan_in.hit;
      scan.handle <= match ? ent.handle : scan_in.handle;
    end
  end

  assign entry_out = ent;
  assign scan_out  = scan;

endmodule

`default_nettype wire

// File: rtl/tlc_ctrl.sv
// tlc_ctrl: request/result registers, sequencer, fill count and the
// excluded-level register. Depends on tlc_pkg.
`default_nettype none

module tlc_ctrl (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  tlc_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output tlc_pkg::out_word_t           out_data,
  input  wire                          cfg_we,
  input  wire [tlc_pkg::LEVEL_W-1:0]   cfg_wdata,
  output tlc_pkg::key_t                req_key,
  output tlc_pkg::cell_ctrl_t          cell_ctrl,
  output tlc_pkg::entry_t              head,
  input  tlc_pkg::scan_t               head_scan,
  input  tlc_pkg::entry_t              tail
);
  import tlc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [SCAN_W-1:0]   cnt, cnt_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [LEVEL_W-1:0]  excluded_level;
  in_word_t            req;
  out_word_t           res;
  logic                load_out;

  assign in_ready = (state == S_IDLE);
  assign req_key  = {req.tile_level, req.tile_x, req.tile_y};

  // new head entry: a touch carries the hit entry's own handle forward
  always_comb begin
    head.valid  = 1'b1;
    head.key    = req_key;
    head.handle = (req.opcode == OP_INSERT) ? req.item_handle : head_scan.handle;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    count_next = count;
    cell_ctrl  = '0;
    load_out   = 1'b0;
    res        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN;
          cnt_next   = '0;
        end
      end
      S_SCAN: begin
        cell_ctrl.scan_en = 1'b1;
        cnt_next          = SCAN_W'(cnt + 1'b1);
        if (cnt == SCAN_W'(CAPACITY - 1)) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          unique case (req.opcode)
            OP_INSERT: begin
              if (req.tile_level == excluded_level) begin
                res.status = ST_IGNORED;
              end else if (head_scan.hit) begin
                cell_ctrl.shift_hit = 1'b1;
                res.status          = ST_UPDATED;
                res.released_valid  = 1'b1;
                res.released_handle = head_scan.handle;
              end else begin
                cell_ctrl.shift_all = 1'b1;
                res.status          = ST_INSERTED;
                if (count == CNT_W'(CAPACITY)) begin
                  // tail slot drops off the end of the chain
                  res.released_valid       = 1'b1;
                  res.released_by_eviction = 1'b1;
                  res.released_handle      = tail.handle;
                end else begin
                  count_next = CNT_W'(count + 1'b1);
                end
              end
            end
            OP_TOUCH: begin
              if (head_scan.hit) begin
                cell_ctrl.shift_hit = 1'b1;
                res.status          = ST_HIT;
              end else begin
                res.status = ST_MISS;
              end
            end
            default: begin
              res.status = head_scan.hit ? ST_HIT : ST_MISS;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.occupancy = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      excluded_level <= '0;
      out_valid      <= 1'b0;
      cnt            <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      cnt   <= cnt_next;
      if (cfg_we) begin
        excluded_level <= cfg_wdata;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    if (load_out) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tile_lru_cache_top.sv
// tile_lru_cache_top: fully associative LRU cache of tile handles.
// Depends on tlc_pkg, tlc_cell and tlc_ctrl.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_ready  | in_data  (tlc_pkg::in_word_t)
//   out     | output    | out_valid/out_ready| out_data (tlc_pkg::out_word_t)
//   cfg     | input     | cfg_we, no wait    | cfg_wdata = excluded level
//
// Timing: a word is accepted in the idle state, scanned in the scan state
// until the hit flag has rippled one cell per cycle along the whole chain,
// then applied in the update state; only then is the next word accepted.
// Reset clears the valid bits, fill count, excluded level and the sequencer;
// there is no clearing pass, so words are taken straight after reset.
// A result waiting on out_ready does not stop the next word being accepted
// and scanned; only the update cycle waits for the output register to free.
`default_nettype none

module tile_lru_cache_top (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  tlc_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  wire                         out_ready,
  output tlc_pkg::out_word_t          out_data,
  input  wire                         cfg_we,
  input  wire [tlc_pkg::LEVEL_W-1:0]  cfg_wdata
);
  import tlc_pkg::*;

  // Cells are kept in recency order: cell 0 most recent, valid entries form
  // a prefix of the chain. Position stands in for the age rank.
  // Entries move away from the head (towards the LRU end) on a shift;
  // the scan result moves towards the head, one cell a cycle, so that at the
  // end of the scan cell i holds "some cell at or beyond i matched" and the
  // matching handle. Those flags also tell each cell whether to move on a
  // promote: exactly cells 0..hit slot carry the flag.
  entry_t     ent_link  [CAPACITY+1];
  scan_t      scan_link [CAPACITY+1];
  key_t       req_key;
  cell_ctrl_t cell_ctrl;

  assign scan_link[CAPACITY] = '0;

  tlc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_key   (req_key),
    .cell_ctrl (cell_ctrl),
    .head      (ent_link[0]),
    .head_scan (scan_link[0]),
    .tail      (ent_link[CAPACITY])   // LRU slot, evicted on a full insert
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    tlc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .req_key   (req_key),
      .ctrl      (cell_ctrl),
      .entry_in  (ent_link[i]),
      .entry_out (ent_link[i+1]),
      .scan_in   (scan_link[i+1]),
      .scan_out  (scan_link[i])
    );
  end

endmodule

`default_nettype wire

// File: rtl/tlc_checker.sv
// tlc_checker: port-level checks on the tile LRU cache, bound to the top.
// Depends on tlc_pkg.
`default_nettype none

module tlc_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input tlc_pkg::out_word_t  out_data
);
  import tlc_pkg::*;

  // held result word stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one word in flight: busy straight after an acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while previous one still in work");

  a_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.occupancy <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.released_by_eviction |->
      out_data.released_valid && out_data.status == ST_INSERTED &&
      out_data.occupancy == OCC_W'(CAPACITY))
    else $error("eviction outside a full insert");

  a_no_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.released_valid |->
      !out_data.released_by_eviction && out_data.released_handle == '0)
    else $error("release fields set without a release");

endmodule

bind tile_lru_cache_top tlc_checker u_tlc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
